@@ rtl/apq_pkg.sv @@
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants of the array priority queue: queue depth,
// command encoding between the front and back parts, and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int TAG_W = 16;
    localparam int PRI_W = 16;
    localparam int OCC_W = 7;

    localparam int S_TDATA_W = ((TAG_W + PRI_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((TAG_W + PRI_W + OCC_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    // command queue between front and back, depth must be a power of two
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_FULL,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [TAG_W-1:0]        tag;
        logic signed [PRI_W-1:0] pri;
        logic [CNT_W-1:0]        occ;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/apq_front.sv @@
// ----------------------------------------------------------------------------
// apq_front
// Accepts request beats, classifies them as insert, remove, full or empty
// against the projected fill count, and hands commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [apq_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic [apq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output apq_pkg::cmd_t                      cmd
);
    import apq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    req_t             req;

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;
    assign accept    = s_tvalid && cmd_ready;
    assign req       = req_t'(s_tuser[0]);

    always_comb
    begin
        cmd.tag    = s_tdata[TAG_W-1:0];
        cmd.pri    = s_tdata[TAG_W+PRI_W-1:TAG_W];
        count_next = count_reg;
        unique case (req)
            REQ_INSERT:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    cmd.op = OP_FULL;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    cmd.op = OP_EMPTY;
                end
                else
                begin
                    cmd.op     = OP_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                cmd.op = OP_EMPTY;
            end
        endcase
        cmd.occ = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/apq_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// apq_cmd_fifo
// Short command queue that decouples request intake from execution.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire apq_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output apq_pkg::cmd_t      out_cmd
);
    import apq_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   level_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (level_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign out_valid = (level_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/apq_cell_row.sv @@
// ----------------------------------------------------------------------------
// apq_cell_row
// Back part: a row of entry cells kept sorted by priority, highest first and
// oldest first among equals, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_cell_row (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire apq_pkg::cmd_t                 cmd,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [apq_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic [apq_pkg::M_TDATA_W-1:0]      m_tdata
);
    import apq_pkg::*;

    logic [TAG_W-1:0]        slot_tag_reg [DEPTH];
    logic signed [PRI_W-1:0] slot_pri_reg [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [DEPTH-1:0]        lower;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [TAG_W-1:0]        out_tag_reg;
    logic signed [PRI_W-1:0] out_pri_reg;
    logic [OCC_W-1:0]        out_occ_reg;

    logic take;
    logic do_insert;
    logic do_remove;

    assign cmd_ready = !out_valid_reg || m_tready;
    assign take      = cmd_valid && cmd_ready;
    assign do_insert = take && (cmd.op == OP_INSERT);
    assign do_remove = take && (cmd.op == OP_REMOVE);

    // lower[i]: cell i is empty or holds a strictly lower priority than the new one
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        assign lower[i] = (IDX >= count_reg) || (slot_pri_reg[i] < cmd.pri);

        always_ff @(posedge clk)
        begin
            if (do_insert && lower[i])
            begin
                if (i == 0)
                begin
                    slot_tag_reg[i] <= cmd.tag;
                    slot_pri_reg[i] <= cmd.pri;
                end
                else if (!lower[(i == 0) ? 0 : i - 1])
                begin
                    slot_tag_reg[i] <= cmd.tag;
                    slot_pri_reg[i] <= cmd.pri;
                end
                else
                begin
                    slot_tag_reg[i] <= slot_tag_reg[(i == 0) ? 0 : i - 1];
                    slot_pri_reg[i] <= slot_pri_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (do_remove && (i < DEPTH - 1))
            begin
                // close up the gap left by the head
                slot_tag_reg[i] <= slot_tag_reg[(i < DEPTH - 1) ? i + 1 : i];
                slot_pri_reg[i] <= slot_pri_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_insert || do_remove)
            begin
                count_reg <= cmd.occ;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_occ_reg <= OCC_W'(cmd.occ);
            out_tag_reg <= '0;
            out_pri_reg <= '0;
            unique case (cmd.op)
                OP_INSERT:
                begin
                    out_status_reg <= ST_OK;
                end
                OP_REMOVE:
                begin
                    out_status_reg <= ST_OK;
                    out_tag_reg    <= slot_tag_reg[0];
                    out_pri_reg    <= slot_pri_reg[0];
                end
                OP_FULL:
                begin
                    out_status_reg <= ST_FULL;
                end
                OP_EMPTY:
                begin
                    out_status_reg <= ST_EMPTY;
                end
                default:
                begin
                    out_status_reg <= ST_EMPTY;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - TAG_W - PRI_W - OCC_W){1'b0}},
                       out_occ_reg, out_pri_reg, out_tag_reg};

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_insert_room : assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |-> (count_reg < CNT_W'(DEPTH)) && (cmd.occ == count_reg + 1'b1))
        else $error("insert issued without room or with wrong occupancy");

    a_remove_dec : assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the row by one");

    a_head_order : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (slot_pri_reg[0] >= slot_pri_reg[1]))
        else $error("head cells out of priority order");

endmodule

`default_nettype wire

@@ rtl/array_priority_queue_unit.sv @@
// Path: a request beat is written into the command queue, and the cell row then takes
// it from there into the result register that drives the result beat.
// Throughput: one request per cycle while m_tready keeps the result port draining; every
// cell of the sorted row updates in parallel on each insert or remove.
// Reset: clears the fill count, the command queue and the result valid flag;
// entry cells are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
// array_priority_queue_unit
// Bounded max-priority queue: insert a tagged entry or remove the highest
// priority entry, oldest first among equal priorities.
// ----------------------------------------------------------------------------
`default_nettype none

module array_priority_queue_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [apq_pkg::S_TUSER_W-1:0] s_tuser,  // [0] req_type
    input  wire logic [apq_pkg::S_TDATA_W-1:0] s_tdata,  // item_tag, item_priority
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [apq_pkg::M_TUSER_W-1:0]      m_tuser,  // [1:0] status
    output logic [apq_pkg::M_TDATA_W-1:0]      m_tdata   // out_tag, out_priority, occupancy
);
    import apq_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    apq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    apq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    apq_cell_row u_cell_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
